FILE: hdl/bscts_pkg.sv
// Shared types and constants for the bitmap set/clear/test/scan block.
// No dependencies; every other file imports this package.
package bscts_pkg;

  localparam int TYPE_W    = 3;
  localparam int POS_W     = 10;
  localparam int LEN_W     = 11;
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = 6;   // log2(WORD_BITS)

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [TYPE_W-1:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_TEST      = 3'd2,
    OP_TEST_SET  = 3'd3,
    OP_TEST_CLR  = 3'd4,
    OP_SCAN      = 3'd5
  } req_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } seq_state_t;

  // Sequencer -> word unit.
  typedef struct packed {
    req_op_t          op;
    logic [IDX_W-1:0] bit_idx;
    logic [LEN_W-1:0] rem;      // bits of the length left from this word on
  } alu_ctl_t;

  // Word unit -> sequencer.
  typedef struct packed {
    logic                 old_bit;
    logic [WORD_BITS-1:0] new_word;
    logic                 any;
    logic [IDX_W-1:0]     low_idx;
  } alu_res_t;

endpackage

FILE: hdl/bscts_if.sv
// Request and response channel interfaces (valid/ready) for the bitmap block.
// Depends on bscts_pkg.
interface bscts_req_if
  import bscts_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [TYPE_W-1:0] req_type;
  logic [POS_W-1:0]  bit_position;

  modport source (output valid, output req_type, output bit_position, input ready);
  modport sink   (input valid, input req_type, input bit_position, output ready);
endinterface

interface bscts_rsp_if
  import bscts_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             found;
  logic [POS_W-1:0] found_position;
  logic             out_of_range;

  modport source (output valid, output bit_value, output found, output found_position,
                  output out_of_range, input ready);
  modport sink   (input valid, input bit_value, input found, input found_position,
                  input out_of_range, output ready);
endinterface

FILE: hdl/bitmap_set_clear_test_scan.sv
// Bitmap with set, clear, test, test-and-set, test-and-reset and find-first-set.
// Top level: sequencer, length register, word store and shared word unit.
// Depends on bscts_pkg, bscts_if, bscts_word_mem and bscts_word_alu.
//
// The vector holds NBITS bits (positions beyond 1023 cannot be addressed, so at
// most 16 words of 64 bits are stored) and reads as all zeros after reset. One
// request is handled at a time; req.ready is high only while the sequencer is
// idle, and the result stays in the output register until taken. A bit op
// goes from accept through a word read (ST_READ) and evaluate/write-back
// (ST_EVAL) to the result beat (ST_DONE); an out-of-range position, an
// unused code, or a scan at zero length goes straight to ST_DONE. A scan
// repeats read and evaluate through the single memory port for each word,
// at most min(16, ceil(length/64)) words. The effective length is
// min(length_bits, NBITS); cfg_we writes length_bits (reset 1024) and is only
// to be used while no request is in flight. Bits beyond a shortened length
// stay stored and reappear when the length is raised again.
module bitmap_set_clear_test_scan
  import bscts_pkg::*;
#(
  parameter int NBITS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  bscts_req_if.sink         req,
  bscts_rsp_if.source       rsp
);

  localparam int NWORDS_ALL = (NBITS + WORD_BITS - 1) / WORD_BITS;
  localparam int MAX_WORDS  = 1 << (POS_W - IDX_W);
  localparam int NWORDS     = (NWORDS_ALL < MAX_WORDS) ? NWORDS_ALL : MAX_WORDS;
  localparam int WADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W      = POS_W - IDX_W + 1;
  localparam int LEN_CAP    = (NBITS < (1 << LEN_W)) ? NBITS : (1 << LEN_W) - 1;

  // config
  logic [LEN_W-1:0] length_bits;
  logic [LEN_W-1:0] eff_len;

  // sequencer
  seq_state_t       state, state_next;
  req_op_t          op;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] widx;

  // result register
  logic             r_bit, r_found, r_oor;
  logic [POS_W-1:0] r_fpos;

  // datapath
  req_op_t              in_op;
  logic                 in_bitop;
  logic                 in_oor;
  logic                 in_mem;
  logic                 accept;
  logic                 is_scan;
  logic [CNT_W-1:0]     widx_inc;
  logic [LEN_W-1:0]     base;
  logic [LEN_W-1:0]     base_next;
  logic                 scan_last;
  logic [WADDR_W-1:0]   mem_addr;
  logic                 mem_re, mem_we;
  logic [WORD_BITS-1:0] rd_word;
  alu_ctl_t             alu_ctl;
  alu_res_t             alu_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_bits <= LEN_RESET;
    end else if (cfg_we) begin
      length_bits <= cfg_wdata;
    end
  end

  assign eff_len = (length_bits > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : length_bits;

  // request decode at accept
  assign accept   = req.valid && req.ready;
  assign in_op    = req_op_t'(req.req_type);
  assign in_bitop = (req.req_type <= TYPE_W'(OP_TEST_CLR));
  assign in_oor   = ({1'b0, req.bit_position} >= eff_len);
  assign in_mem   = (in_bitop && !in_oor) || (in_op == OP_SCAN && eff_len != '0);

  // scan walk
  assign is_scan   = (op == OP_SCAN);
  assign widx_inc  = widx + CNT_W'(1);
  assign base      = {widx, {IDX_W{1'b0}}};
  assign base_next = {widx_inc, {IDX_W{1'b0}}};
  assign scan_last = (widx_inc >= CNT_W'(NWORDS)) || (base_next >= eff_len);

  assign mem_addr = is_scan ? widx[WADDR_W-1:0] : pos[IDX_W +: WADDR_W];

  assign alu_ctl.op      = op;
  assign alu_ctl.bit_idx = pos[IDX_W-1:0];
  assign alu_ctl.rem     = eff_len - base;

  bscts_word_mem #(
    .NWORDS  (NWORDS),
    .WADDR_W (WADDR_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (alu_res.new_word),
    .rdata (rd_word)
  );

  bscts_word_alu u_alu (
    .word (rd_word),
    .ctl  (alu_ctl),
    .res  (alu_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = in_mem ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (is_scan && !alu_res.any && !scan_last) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_READ: mem_re = 1'b1;
      ST_EVAL: begin
        case (op)
          OP_SET, OP_CLEAR, OP_TEST_SET, OP_TEST_CLR: mem_we = 1'b1;
          default:                                    mem_we = 1'b0;
        endcase
      end
      ST_DONE: rsp.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request registers and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= in_op;
      pos     <= req.bit_position;
      widx    <= '0;
      r_bit   <= 1'b0;
      r_found <= 1'b0;
      r_fpos  <= '0;
      r_oor   <= in_bitop && in_oor;
    end else if (state == ST_EVAL) begin
      if (is_scan) begin
        if (alu_res.any) begin
          r_found <= 1'b1;
          r_fpos  <= {widx[POS_W-IDX_W-1:0], alu_res.low_idx};
        end else begin
          widx <= widx_inc;
        end
      end else begin
        case (op)
          OP_TEST, OP_TEST_SET, OP_TEST_CLR: r_bit <= alu_res.old_bit;
          default:                           r_bit <= 1'b0;
        endcase
      end
    end
  end

  assign rsp.bit_value      = r_bit;
  assign rsp.found          = r_found;
  assign rsp.found_position = r_fpos;
  assign rsp.out_of_range   = r_oor;

  // checks
  a_found_not_oor: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> !rsp.out_of_range)
    else $error("found and out_of_range both set");

  a_found_in_len: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> ({1'b0, rsp.found_position} < eff_len))
    else $error("scan hit at or beyond the effective length");

  a_no_write_oor: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_EVAL && !r_oor && !is_scan))
    else $error("word written outside a valid bit operation");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (widx < CNT_W'(NWORDS)))
    else $error("scan index beyond stored words");

  a_accept_flow: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_READ || state == ST_DONE))
    else $error("accepted request did not start");

endmodule

FILE: hdl/bscts_word_mem.sv
// Word store of the bitmap: one read or write port, registered read data.
// Per-word valid bits make unwritten words read as zero after reset. Uses bscts_pkg.
module bscts_word_mem
  import bscts_pkg::*;
#(
  parameter int NWORDS  = 16,
  parameter int WADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 re,
  input  logic                 we,
  input  logic [WADDR_W-1:0]   addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[addr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[addr];
      end
    end
  end

  assign rdata = rd_valid ? rd_data : '0;

endmodule

FILE: hdl/bscts_word_alu.sv
// Shared word unit: bit read-modify-write and masked lowest-set-bit search.
// Purely combinational; used once per word visit. Uses bscts_pkg.
module bscts_word_alu
  import bscts_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  alu_ctl_t             ctl,
  output alu_res_t             res
);

  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] len_mask;
  logic [WORD_BITS-1:0] masked;
  logic [IDX_W-1:0]     low;

  always_comb begin
    bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << ctl.bit_idx;
    // tail mask when the length ends inside this word
    if (ctl.rem[LEN_W-1:IDX_W] == '0) begin
      len_mask = ~({WORD_BITS{1'b1}} << ctl.rem[IDX_W-1:0]);
    end else begin
      len_mask = {WORD_BITS{1'b1}};
    end
    masked = word & len_mask;

    low = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        low = IDX_W'(i);
      end
    end

    res.old_bit = word[ctl.bit_idx];
    res.any     = |masked;
    res.low_idx = low;
    case (ctl.op)
      OP_SET, OP_TEST_SET:   res.new_word = word | bit_mask;
      OP_CLEAR, OP_TEST_CLR: res.new_word = word & ~bit_mask;
      default:               res.new_word = word;
    endcase
  end

endmodule
